### hdl/assert_macros.svh
// Assertion macros used by the edge statistics back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ESDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("esds assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ESDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("esds assertion failed");

`else

`define ESDS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ESDS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### hdl/esds_pkg.sv
// Shared constants and types of the edge stream degree statistics block.
package esds_pkg;

  localparam int VERTEX_BITS = 20;
  localparam int DEGREE_BITS = 24;

  localparam int VID_W       = 20;
  localparam int ADDR_W      = (VERTEX_BITS < VID_W) ? VERTEX_BITS : VID_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  localparam int EDGE_W  = 32;
  localparam int WEDGE_W = 56;
  localparam int STAR_W  = 64;
  localparam int PROD_W  = 2 * DEGREE_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;

  typedef logic [VID_W-1:0]       vid_t;
  typedef logic [ADDR_W-1:0]      vaddr_t;
  typedef logic [DEGREE_BITS-1:0] degree_t;

  typedef struct packed {
    logic   counted;
    vaddr_t src;
    vaddr_t dst;
  } item_t;

  typedef struct packed {
    logic               counted;
    logic [EDGE_W-1:0]  edge_count;
    vid_t               max_vertex;
    logic [WEDGE_W-1:0] wedge_count;
    logic [STAR_W-1:0]  star_count;
  } result_t;

endpackage

### hdl/edge_stream_degree_statistics.sv
// Top level of the streaming edge degree, wedge and three-star statistics block.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   in_src_vertex, in_dst_vertex
//   out      output     out_valid / out_ready out_counted, out_edge_count,
//                                             out_max_vertex, out_wedge_count,
//                                             out_star_count
//
// An edge's two degree updates share the store's single write port, so an edge is
// read from the store only once the one before it has left the first stage.
// Each edge passes the front register, the queue, stages s1 to s3, the result buffer.
// After reset all 2^20 store entries are swept to zero; edges queue meanwhile.
// A stalled output fills a four-entry result buffer and then holds back new edges;
// the input keeps taking edges until the front register and the queue are full.
module edge_stream_degree_statistics import esds_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VID_W-1:0]   in_src_vertex,
  input  logic [VID_W-1:0]   in_dst_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_counted,
  output logic [EDGE_W-1:0]  out_edge_count,
  output logic [VID_W-1:0]   out_max_vertex,
  output logic [WEDGE_W-1:0] out_wedge_count,
  output logic [STAR_W-1:0]  out_star_count
);

  // Front register to queue.
  logic    fq_valid;
  item_t   fq_item;
  logic    fq_ready;

  // Queue to back end.
  logic    qb_valid;
  item_t   qb_item;
  logic    qb_ready;

  result_t res_data;

  // The front end trims ids to the store address width and flags self-loops,
  // so the back end never has to look at the raw ports.
  esds_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_src_vertex (in_src_vertex),
    .in_dst_vertex (in_dst_vertex),
    .push_valid    (fq_valid),
    .push_item     (fq_item),
    .push_ready    (fq_ready)
  );

  // The queue lets the front keep taking transfers while the back end is
  // busy with a store update or waiting on the result side.
  esds_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_item  (fq_item),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_item   (qb_item),
    .pop_ready  (qb_ready)
  );

  // The back end owns the degree store, the running totals and the result
  // buffer that drives the output channel.
  esds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_item    (qb_item),
    .q_ready   (qb_ready),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res_data  (res_data)
  );

  assign out_counted     = res_data.counted;
  assign out_edge_count  = res_data.edge_count;
  assign out_max_vertex  = res_data.max_vertex;
  assign out_wedge_count = res_data.wedge_count;
  assign out_star_count  = res_data.star_count;

endmodule

### hdl/esds_front.sv
// Front end: takes edges, trims the ids and marks self-loops.
module esds_front import esds_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  vid_t   in_src_vertex,
  input  vid_t   in_dst_vertex,
  output logic   push_valid,
  output item_t  push_item,
  input  logic   push_ready
);

  logic  hold_valid_r;
  item_t hold_item_r;
  item_t item_nxt;

  // Only the low address bits of an id take part in anything downstream.
  always_comb begin
    item_nxt.src     = in_src_vertex[ADDR_W-1:0];
    item_nxt.dst     = in_dst_vertex[ADDR_W-1:0];
    item_nxt.counted = (in_src_vertex[ADDR_W-1:0] != in_dst_vertex[ADDR_W-1:0]);
  end

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_item  = hold_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid_r <= 1'b1;
    end else if (push_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item_r <= item_nxt;
    end
  end

endmodule

### hdl/esds_queue.sv
// Short queue of classified edges between the front and back ends.
module esds_queue import esds_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  item_t entry_r [QUEUE_DEPTH];
  ptr_t  wr_ptr_r;
  ptr_t  rd_ptr_r;
  cnt_t  count_r;
  logic  do_push;
  logic  do_pop;

  assign push_ready = (count_r != cnt_t'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hdl/esds_back.sv
// Back end: degree store updates, running totals and the result buffer.
`include "assert_macros.svh"

module esds_back import esds_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_ready,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_data
);

  localparam int OPTR_W   = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OCNT_W   = $clog2(OUT_DEPTH + 1);
  localparam int CREDIT_W = OCNT_W + 1;

  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [DEGREE_BITS:0] wsum_t;
  typedef logic [EDGE_W:0]     edge_ext_t;
  typedef logic [WEDGE_W:0]    wedge_ext_t;
  typedef logic [STAR_W:0]     star_ext_t;
  typedef logic [OPTR_W-1:0]   optr_t;
  typedef logic [OCNT_W-1:0]   ocnt_t;
  typedef logic [CREDIT_W-1:0] credit_t;

  localparam degree_t DEG_MAX = '1;

  // Clearing pass over the degree store after reset.
  logic    clear_active_r;
  vaddr_t  clear_addr_r;

  // Degree store with two registered read ports and one write port.
  degree_t store_mem [STORE_DEPTH];
  degree_t rd_src_r;
  degree_t rd_dst_r;
  logic    we;
  vaddr_t  wa;
  degree_t wd;

  // Most recent write, to cover a read that races it.
  vaddr_t  lw_addr_r;
  degree_t lw_data_r;

  logic    issue;
  credit_t credit;

  logic    s1_valid_r;
  item_t   s1_item_r;
  degree_t src_deg;
  degree_t dst_deg;
  degree_t src_inc;
  degree_t dst_inc;
  degree_t src_dm1;
  degree_t dst_dm1;
  prod_t   prod_src;
  prod_t   prod_dst;
  wsum_t   wsum;

  logic    pend_valid_r;
  vaddr_t  pend_addr_r;
  degree_t pend_data_r;

  logic    s2_valid_r;
  item_t   s2_item_r;
  prod_t   s2_prod_src_r;
  prod_t   s2_prod_dst_r;
  wsum_t   s2_wsum_r;
  prod_t   csum;

  logic    s3_valid_r;
  item_t   s3_item_r;
  prod_t   s3_csum_r;
  wsum_t   s3_wsum_r;

  logic [EDGE_W-1:0]  edge_total_r;
  logic [EDGE_W-1:0]  edge_total_nxt;
  vaddr_t             largest_r;
  vaddr_t             largest_nxt;
  vaddr_t             largest_mid;
  logic [WEDGE_W-1:0] wedge_total_r;
  logic [WEDGE_W-1:0] wedge_total_nxt;
  logic [STAR_W-1:0]  star_total_r;
  logic [STAR_W-1:0]  star_total_nxt;
  edge_ext_t          edge_sum;
  wedge_ext_t         wedge_sum;
  star_ext_t          star_sum;
  result_t            res_push;

  result_t out_mem_r [OUT_DEPTH];
  optr_t   wr_ptr_r;
  optr_t   rd_ptr_r;
  ocnt_t   out_count_r;
  logic    res_pop;

  // An edge is issued only when the previous one has left the first stage
  // and the result buffer has room for everything already in flight.
  always_comb begin
    credit = credit_t'(out_count_r) + credit_t'(s1_valid_r)
           + credit_t'(s2_valid_r) + credit_t'(s3_valid_r);
    issue  = q_valid && !clear_active_r && !s1_valid_r
           && (credit < credit_t'(OUT_DEPTH));
  end

  assign q_ready = issue;

  always_comb begin
    we = 1'b0;
    wa = pend_addr_r;
    wd = pend_data_r;
    if (clear_active_r) begin
      we = 1'b1;
      wa = clear_addr_r;
      wd = '0;
    end else if (s1_valid_r && s1_item_r.counted) begin
      we = 1'b1;
      wa = s1_item_r.src;
      wd = src_inc;
    end else if (pend_valid_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_src_r <= store_mem[q_item.src];
      rd_dst_r <= store_mem[q_item.dst];
    end
    if (we) begin
      store_mem[wa] <= wd;
    end
  end

  always_comb begin
    src_deg  = (lw_addr_r == s1_item_r.src) ? lw_data_r : rd_src_r;
    dst_deg  = (lw_addr_r == s1_item_r.dst) ? lw_data_r : rd_dst_r;
    src_inc  = (src_deg == DEG_MAX) ? src_deg : src_deg + 1'b1;
    dst_inc  = (dst_deg == DEG_MAX) ? dst_deg : dst_deg + 1'b1;
    // A zero degree gives a zero product whatever the wrapped factor is.
    src_dm1  = src_deg - 1'b1;
    dst_dm1  = dst_deg - 1'b1;
    prod_src = prod_t'(src_deg) * prod_t'(src_dm1);
    prod_dst = prod_t'(dst_deg) * prod_t'(dst_dm1);
    wsum     = wsum_t'(src_deg) + wsum_t'(dst_deg);
  end

  always_comb begin
    csum = (s2_prod_src_r >> 1) + (s2_prod_dst_r >> 1);
  end

  always_comb begin
    edge_sum    = edge_ext_t'(edge_total_r) + 1'b1;
    wedge_sum   = wedge_ext_t'(wedge_total_r) + wedge_ext_t'(s3_wsum_r);
    star_sum    = star_ext_t'(star_total_r) + star_ext_t'(s3_csum_r);
    largest_mid = (s3_item_r.src > largest_r) ? s3_item_r.src : largest_r;

    edge_total_nxt  = edge_total_r;
    wedge_total_nxt = wedge_total_r;
    star_total_nxt  = star_total_r;
    largest_nxt     = largest_r;
    if (s3_item_r.counted) begin
      edge_total_nxt  = edge_sum[EDGE_W] ? '1 : edge_sum[EDGE_W-1:0];
      wedge_total_nxt = wedge_sum[WEDGE_W] ? '1 : wedge_sum[WEDGE_W-1:0];
      star_total_nxt  = star_sum[STAR_W] ? '1 : star_sum[STAR_W-1:0];
      largest_nxt     = (s3_item_r.dst > largest_mid) ? s3_item_r.dst : largest_mid;
    end

    res_push.counted     = s3_item_r.counted;
    res_push.edge_count  = edge_total_nxt;
    res_push.max_vertex  = vid_t'(largest_nxt);
    res_push.wedge_count = wedge_total_nxt;
    res_push.star_count  = star_total_nxt;
  end

  assign res_valid = (out_count_r != '0);
  assign res_data  = out_mem_r[rd_ptr_r];
  assign res_pop   = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_active_r <= 1'b1;
      clear_addr_r   <= '0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      s3_valid_r     <= 1'b0;
      pend_valid_r   <= 1'b0;
      edge_total_r   <= '0;
      largest_r      <= '0;
      wedge_total_r  <= '0;
      star_total_r   <= '0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      out_count_r    <= '0;
    end else begin
      if (clear_active_r) begin
        if (clear_addr_r == '1) begin
          clear_active_r <= 1'b0;
        end
        clear_addr_r <= clear_addr_r + 1'b1;
      end
      s1_valid_r   <= issue;
      s2_valid_r   <= s1_valid_r;
      s3_valid_r   <= s2_valid_r;
      pend_valid_r <= s1_valid_r && s1_item_r.counted;
      if (s3_valid_r) begin
        edge_total_r  <= edge_total_nxt;
        largest_r     <= largest_nxt;
        wedge_total_r <= wedge_total_nxt;
        star_total_r  <= star_total_nxt;
        wr_ptr_r      <= (wr_ptr_r == optr_t'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (res_pop) begin
        rd_ptr_r <= (rd_ptr_r == optr_t'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (s3_valid_r && !res_pop) begin
        out_count_r <= out_count_r + 1'b1;
      end else if (res_pop && !s3_valid_r) begin
        out_count_r <= out_count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lw_addr_r <= wa;
      lw_data_r <= wd;
    end
    if (issue) begin
      s1_item_r <= q_item;
    end
    if (s1_valid_r) begin
      pend_addr_r   <= s1_item_r.dst;
      pend_data_r   <= dst_inc;
      s2_item_r     <= s1_item_r;
      s2_prod_src_r <= prod_src;
      s2_prod_dst_r <= prod_dst;
      s2_wsum_r     <= wsum;
    end
    if (s2_valid_r) begin
      s3_item_r <= s2_item_r;
      s3_csum_r <= csum;
      s3_wsum_r <= s2_wsum_r;
    end
    if (s3_valid_r) begin
      out_mem_r[wr_ptr_r] <= res_push;
    end
  end

  `ESDS_ASSERT_NXT(a_issue_spacing, clk, rst_n, issue, !issue)
  `ESDS_ASSERT_IMP(a_single_writer, clk, rst_n, s1_valid_r && s1_item_r.counted, !pend_valid_r && !clear_active_r)
  `ESDS_ASSERT_IMP(a_result_room, clk, rst_n, s3_valid_r, out_count_r < OUT_DEPTH)
  `ESDS_ASSERT_IMP(a_clear_quiet, clk, rst_n, clear_active_r, !s1_valid_r && !s2_valid_r && !s3_valid_r && out_count_r == '0)

endmodule

### dv/edge_stream_degree_statistics_tb.sv
// Testbench for the edge stream degree statistics block, checked against a predictor.
`timescale 1ns / 1ps

module edge_stream_degree_statistics_tb import esds_pkg::*; ();

  localparam int CLK_HALF_NS      = 4;
  localparam int RESET_CYCLES     = 6;
  localparam int RANDOM_PER_PHASE = 180;
  localparam int HOLD_OFF_EDGES   = 30;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int DRAIN_CYCLES     = 32;
  localparam int POOL_SIZE        = 16;

  // The degree store is swept to zero after reset, and no edge is processed before
  // the sweep ends. The limit leaves a wide margin over the sweep and the rest of
  // the run.
  localparam longint CYCLE_LIMIT = 64'd4 * 64'd1048576;

  localparam logic [EDGE_W-1:0]  EDGE_SAT   = '1;
  localparam logic [WEDGE_W-1:0] WEDGE_SAT  = '1;
  localparam logic [STAR_W-1:0]  STAR_SAT   = '1;
  localparam degree_t            DEGREE_SAT = '1;
  localparam vid_t               VID_TOP    = '1;

  typedef struct packed {
    vid_t src;
    vid_t dst;
  } edge_item_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  vid_t               in_src_vertex = '0;
  vid_t               in_dst_vertex = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               out_counted;
  logic [EDGE_W-1:0]  out_edge_count;
  vid_t               out_max_vertex;
  logic [WEDGE_W-1:0] out_wedge_count;
  logic [STAR_W-1:0]  out_star_count;

  edge_stream_degree_statistics dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_src_vertex   (in_src_vertex),
    .in_dst_vertex   (in_dst_vertex),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_counted     (out_counted),
    .out_edge_count  (out_edge_count),
    .out_max_vertex  (out_max_vertex),
    .out_wedge_count (out_wedge_count),
    .out_star_count  (out_star_count)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF_NS;
    clk = 1'b1;
    #CLK_HALF_NS;
  end

  // Predicted state of the block. The degree table is sparse: a vertex that was
  // never touched reads as zero, just as the cleared store does.
  degree_t            degree_of [vaddr_t];
  logic [EDGE_W-1:0]  edges_seen = '0;
  vid_t               top_vertex = '0;
  logic [WEDGE_W-1:0] wedge_sum  = '0;
  logic [STAR_W-1:0]  star_sum   = '0;

  // Totals expected on the result channel, oldest first, and edges not yet offered.
  result_t    totals_expected [$];
  edge_item_t edges_pending [$];
  edge_item_t next_edge;
  result_t    oldest_totals;

  // Idling controls, changed by the stimulus process between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_holding     = 1'b0;

  vid_t   hub_pool [POOL_SIZE];
  int     mismatch_count = 0;
  longint cycle_count    = 0;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
    if (a >= cap || b > cap - a) begin
      return cap;
    end
    return a + b;
  endfunction

  // Number of vertex pairs among deg neighbors, i.e. deg choose two.
  function automatic logic [63:0] pairs_of(degree_t deg);
    logic [63:0] d64;
    d64 = 64'(deg);
    if (d64 < 64'd2) begin
      return '0;
    end
    return (d64 * (d64 - 64'd1)) >> 1;
  endfunction

  // Applies one accepted edge to the predicted state and queues the totals that
  // the block must return for it. Self-loops leave everything untouched.
  task automatic tally_edge(vid_t src, vid_t dst);
    vaddr_t  sa;
    vaddr_t  da;
    degree_t ds;
    degree_t dd;
    result_t totals;
    sa = src[ADDR_W-1:0];
    da = dst[ADDR_W-1:0];
    totals.counted = (sa != da);
    if (totals.counted) begin
      ds = degree_of.exists(sa) ? degree_of[sa] : '0;
      dd = degree_of.exists(da) ? degree_of[da] : '0;
      edges_seen = EDGE_W'(sat_add(64'(edges_seen), 64'd1, 64'(EDGE_SAT)));
      if (VID_W'(sa) > top_vertex) begin
        top_vertex = VID_W'(sa);
      end
      if (VID_W'(da) > top_vertex) begin
        top_vertex = VID_W'(da);
      end
      // Wedges and stars use the degrees as they were before this edge.
      wedge_sum = WEDGE_W'(sat_add(64'(wedge_sum), 64'(ds), 64'(WEDGE_SAT)));
      wedge_sum = WEDGE_W'(sat_add(64'(wedge_sum), 64'(dd), 64'(WEDGE_SAT)));
      star_sum  = sat_add(star_sum, pairs_of(ds), STAR_SAT);
      star_sum  = sat_add(star_sum, pairs_of(dd), STAR_SAT);
      if (ds < DEGREE_SAT) begin
        degree_of[sa] = ds + 1'b1;
      end
      if (dd < DEGREE_SAT) begin
        degree_of[da] = dd + 1'b1;
      end
    end
    totals.edge_count  = edges_seen;
    totals.max_vertex  = top_vertex;
    totals.wedge_count = wedge_sum;
    totals.star_count  = star_sum;
    totals_expected.push_back(totals);
  endtask

  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("cycle %0d: %s mismatch, got %0h, expected %0h", cycle_count, field, got, want);
    mismatch_count++;
  endtask

  task automatic queue_edge(vid_t src, vid_t dst);
    edges_pending.push_back({src, dst});
  endtask

  // Most random edges run between a small set of hub vertices, so that degrees
  // climb high enough to make the wedge and star totals interesting. The rest
  // are edges over the full id range, hub-to-anywhere edges and self-loops.
  task automatic pick_random_edge(output vid_t src, output vid_t dst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      src = hub_pool[$urandom_range(0, POOL_SIZE - 1)];
      dst = hub_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (roll < 85) begin
      src = VID_W'($urandom_range(0, (1 << VID_W) - 1));
      dst = VID_W'($urandom_range(0, (1 << VID_W) - 1));
    end else if (roll < 93) begin
      src = hub_pool[$urandom_range(0, POOL_SIZE - 1)];
      dst = VID_W'($urandom_range(0, (1 << VID_W) - 1));
      if ($urandom_range(0, 1) == 0) begin
        {src, dst} = {dst, src};
      end
    end else begin
      src = ($urandom_range(0, 1) == 0) ? hub_pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : VID_W'($urandom_range(0, (1 << VID_W) - 1));
      dst = src;
    end
  endtask

  // The sender is quiet until every expected result has come back. The check
  // runs on the falling edge, after the driver's updates have settled.
  task automatic wait_for_idle();
    while (edges_pending.size() != 0 || in_valid || totals_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Input driver. An edge is predicted at the edge where its transfer happens,
  // using the payload that was on the ports during that cycle. A new edge is
  // only offered once the previous one has been taken, and valid stays high
  // across back-to-back transfers without dropping.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tally_edge(in_src_vertex, in_dst_vertex);
      end
      if (!in_valid || in_ready) begin
        if (edges_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_edge = edges_pending.pop_front();
          in_valid      <= 1'b1;
          in_src_vertex <= next_edge.src;
          in_dst_vertex <= next_edge.dst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each result transfer is compared field by field with the
  // oldest expectation. Ready stalls at random, and is held low for the whole
  // of a long hold-off.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (totals_expected.size() == 0) begin
          flag_mismatch("unexpected result, edge_count", 64'(out_edge_count), '0);
        end else begin
          oldest_totals = totals_expected.pop_front();
          if (out_counted != oldest_totals.counted) begin
            flag_mismatch("counted", 64'(out_counted), 64'(oldest_totals.counted));
          end
          if (out_edge_count != oldest_totals.edge_count) begin
            flag_mismatch("edge_count", 64'(out_edge_count), 64'(oldest_totals.edge_count));
          end
          if (out_max_vertex != oldest_totals.max_vertex) begin
            flag_mismatch("max_vertex", 64'(out_max_vertex), 64'(oldest_totals.max_vertex));
          end
          if (out_wedge_count != oldest_totals.wedge_count) begin
            flag_mismatch("wedge_count", 64'(out_wedge_count),
                          64'(oldest_totals.wedge_count));
          end
          if (out_star_count != oldest_totals.star_count) begin
            flag_mismatch("star_count", out_star_count, oldest_totals.star_count);
          end
        end
      end
      out_ready <= !rx_holding && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("edge_stream_degree_statistics_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    vid_t src;
    vid_t dst;
    int   phase;
    int   k;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    hub_pool[0] = '0;
    hub_pool[1] = VID_TOP;
    for (k = 2; k < POOL_SIZE; k++) begin
      hub_pool[k] = VID_W'($urandom_range(0, (1 << VID_W) - 1));
    end

    // Directed edges. These are offered while the store is still being swept
    // after reset, so the first ones sit in the input queue for a long time.
    // A self-loop on an empty graph returns all-zero totals.
    queue_edge('0, '0);
    // Extreme ids in both orders; the repeat gives both endpoints degree two,
    // so the star total starts to move.
    queue_edge('0, VID_TOP);
    queue_edge(VID_TOP, '0);
    queue_edge('0, VID_TOP);
    queue_edge(VID_TOP, VID_TOP);
    // A hub on vertex zero, with degree climbing one per edge.
    queue_edge('0, 20'd1);
    queue_edge('0, 20'd2);
    queue_edge(20'd3, '0);
    queue_edge('0, 20'd4);
    queue_edge(20'd5, '0);
    // Alternating bit patterns and the mid-range boundary.
    queue_edge(20'hAAAAA, 20'h55555);
    queue_edge(20'h55555, 20'hAAAAA);
    queue_edge(20'h7FFFF, 20'h80000);
    queue_edge(20'hFFFFE, VID_TOP);
    queue_edge(20'd1, 20'd2);
    queue_edge(20'd2, 20'd1);
    // Self-loops once the totals are nonzero must return them unchanged.
    queue_edge(20'h12345, 20'h12345);
    queue_edge('0, '0);
    queue_edge(20'd1, 20'h12345);
    wait_for_idle();

    // Random phases: no idling, sender gaps, receiver stalls, then light idling
    // on both sides. Every phase drains fully before the next one starts.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= 49;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 49;
        end
        default: begin
          send_idle_pct  <= 6;
          recv_stall_pct <= 6;
        end
      endcase
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        pick_random_edge(src, dst);
        queue_edge(src, dst);
      end
      wait_for_idle();
    end

    // Back pressure: the receiver holds off for a long stretch while the sender
    // keeps offering edges, so the result buffer and input queue fill up and
    // in_ready drops. Then everything drains before the end.
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    rx_holding     <= 1'b1;
    for (k = 0; k < HOLD_OFF_EDGES; k++) begin
      pick_random_edge(src, dst);
      queue_edge(src, dst);
    end
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    rx_holding <= 1'b0;
    wait_for_idle();

    // Give any stray result time to show up before judging the run.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (totals_expected.size() != 0) begin
      flag_mismatch("missing results", 64'(totals_expected.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("edge_stream_degree_statistics_tb: done, clean");
    end else begin
      $display("edge_stream_degree_statistics_tb: done, errors");
    end
    $finish;
  end

endmodule
